// ===== sv/lcc_pkg.sv =====
// shared constants, register indexes and sequencer states for the coefficient codec
`default_nettype none

package lcc_pkg;

    // fixed field widths
    localparam int SAMPLE_W    = 14;
    localparam int VALUE_W     = 13;
    localparam int BYTE_W      = 8;
    localparam int CODE_BITS_W = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_RESULTS = 3;

    // defaults for the top level parameters
    localparam int DEF_MAX_CODE_BITS = 11;
    localparam int DEF_MODULUS_WIDTH = 13;

    // narrowest code width accepted when unpacking
    localparam int MIN_DECOMP_BITS = 3;

    // register reset values
    localparam logic [CODE_BITS_W-1:0] RST_CODE_BITS = 4'd10;
    localparam int                     RST_MODULUS   = 7681;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd2;

    // direction codes
    localparam logic DIR_COMPRESS   = 1'b0;
    localparam logic DIR_DECOMPRESS = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_FIX,
        S_DIV,
        S_RADD,
        S_RCMP,
        S_PACK,
        S_CEMIT,
        S_DCHK,
        S_MUL,
        S_MRND,
        S_MOUT
    } t_state;

endpackage

`default_nettype wire

// ===== sv/lattice_coeff_compress_codec.sv =====
// coefficient compress / decompress codec built around one shared add-subtract unit
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  input   | in        | i_valid / o_stall          | i_sample, i_final_item
//  output  | out       | o_valid / i_stall          | o_value, o_final_result
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// compress: a 14 step modulo reduction, d quotient steps, rounding and packing per
// coefficient, then the complete bytes are emitted.
// decompress: d shift-add multiply steps and a rounding add per code.
// reduction, quotient, rounding and multiply steps use the single add-subtract unit.
// reset is synchronous; it clears the sequencer, the output beat and the bit buffer.
// a stalled output beat holds the sequencer at its next result, but a new input beat
// is taken as soon as the sequencer is idle, even while the last result waits.
`default_nettype none

module lattice_coeff_compress_codec #(
    parameter int MAX_CODE_BITS = lcc_pkg::DEF_MAX_CODE_BITS,
    parameter int MODULUS_WIDTH = lcc_pkg::DEF_MODULUS_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input beats
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [lcc_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_final_item,
    // output beats
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic        [lcc_pkg::VALUE_W-1:0]   o_value,
    output logic                                 o_final_result,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [lcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [MODULUS_WIDTH-1:0]      i_cfg_data
);
    import lcc_pkg::*;

    localparam int BUF_W    = MAX_CODE_BITS + BYTE_W - 1;
    localparam int CNT_W    = $clog2(BUF_W + 1);
    localparam int D_W      = $clog2(MAX_CODE_BITS + 1);
    localparam int ADD_W    = MAX_CODE_BITS + MODULUS_WIDTH;
    localparam int STEP_MAX = (SAMPLE_W > MAX_CODE_BITS) ? SAMPLE_W : MAX_CODE_BITS;
    localparam int STEP_W   = $clog2(STEP_MAX + 1);
    localparam int NRES_W   = $clog2(MAX_RESULTS + 1);
    localparam int MW       = MODULUS_WIDTH;

    // control registers
    t_state                   r_state, n_state;
    logic                     r_dir, n_dir;
    logic [CODE_BITS_W-1:0]   r_code_bits, n_code_bits;
    logic [MW-1:0]            r_modulus, n_modulus;
    logic [BUF_W-1:0]         r_buf, n_buf;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_out_valid, n_out_valid;

    // working registers
    logic [STEP_W-1:0]        r_step, n_step;
    logic [NRES_W-1:0]        r_nres, n_nres;
    logic                     r_fin, n_fin;
    logic                     r_neg, n_neg;
    logic [SAMPLE_W-1:0]      r_mag, n_mag;
    logic [MW-1:0]            r_rem, n_rem;
    logic [MAX_CODE_BITS-1:0] r_quo, n_quo;
    logic [MAX_CODE_BITS-1:0] r_mcode, n_mcode;
    logic [ADD_W-1:0]         r_acc, n_acc;
    logic                     r_res_last, n_res_last;
    logic [VALUE_W-1:0]       r_out_value, n_out_value;
    logic                     r_out_final, n_out_final;

    // effective code width
    logic [D_W-1:0] eff_bits;
    always_comb begin
        if (r_code_bits == '0) begin
            eff_bits = D_W'(1);
        end else if (r_code_bits > CODE_BITS_W'(MAX_CODE_BITS)) begin
            eff_bits = D_W'(MAX_CODE_BITS);
        end else begin
            eff_bits = r_code_bits[D_W-1:0];
        end
        if (r_dir == DIR_DECOMPRESS && eff_bits < D_W'(MIN_DECOMP_BITS)) begin
            eff_bits = D_W'(MIN_DECOMP_BITS);
        end
    end

    // low d bits mask
    logic [MAX_CODE_BITS-1:0] code_mask;
    assign code_mask = ~({MAX_CODE_BITS{1'b1}} << eff_bits);

    // shared add-subtract unit, add_ok is the carry out (no borrow on subtract)
    logic [ADD_W-1:0] add_a, add_b;
    logic             add_sub;
    logic [ADD_W:0]   add_sum;
    logic             add_ok;
    assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + {{ADD_W{1'b0}}, add_sub};
    assign add_ok  = add_sum[ADD_W];

    // long division partial remainders
    logic [MW:0] mod_part, div_part;
    assign mod_part = {r_rem, r_mag[SAMPLE_W-1]};
    assign div_part = {r_rem, 1'b0};

    // operand selection for the shared unit
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (r_state)
            S_MOD: begin
                add_a   = ADD_W'(mod_part);
                add_b   = ADD_W'(r_modulus);
                add_sub = 1'b1;
            end
            S_FIX: begin
                add_a   = ADD_W'(r_modulus);
                add_b   = ADD_W'(r_rem);
                add_sub = 1'b1;
            end
            S_DIV: begin
                add_a   = ADD_W'(div_part);
                add_b   = ADD_W'(r_modulus);
                add_sub = 1'b1;
            end
            S_RADD: begin
                add_a   = ADD_W'(r_rem);
                add_b   = ADD_W'(r_modulus >> 1);
            end
            S_RCMP: begin
                add_a   = r_acc;
                add_b   = ADD_W'(r_modulus);
                add_sub = 1'b1;
            end
            S_MUL: begin
                add_a   = {r_acc[ADD_W-2:0], 1'b0};
                add_b   = r_mcode[MAX_CODE_BITS-1] ? ADD_W'(r_modulus) : '0;
            end
            S_MRND: begin
                add_a   = r_acc;
                add_b   = ADD_W'(1) << (eff_bits - D_W'(1));
            end
            default: begin
                add_a   = '0;
            end
        endcase
    end

    // helper terms for the emit decisions
    logic [SAMPLE_W-1:0]      smp_u;
    logic                     out_free;
    logic                     room;
    logic [NRES_W-1:0]        nres_inc;
    logic [CNT_W-1:0]         cnt_less8, cnt_lessd;
    logic [MAX_CODE_BITS-1:0] dcode;
    logic [D_W-1:0]           align_sh;
    logic                     more_c, more_d;

    assign smp_u     = i_sample;
    assign out_free  = !r_out_valid || !i_stall;
    assign room      = r_nres < NRES_W'(MAX_RESULTS);
    assign nres_inc  = r_nres + NRES_W'(1);
    assign cnt_less8 = r_cnt - CNT_W'(BYTE_W);
    assign cnt_lessd = r_cnt - CNT_W'(eff_bits);
    assign dcode     = r_buf[MAX_CODE_BITS-1:0] & code_mask;
    assign align_sh  = D_W'(MAX_CODE_BITS) - eff_bits;
    assign more_c    = (nres_inc < NRES_W'(MAX_RESULTS))
                     && ((cnt_less8 >= CNT_W'(BYTE_W)) || (r_fin && cnt_less8 != '0));
    assign more_d    = (nres_inc < NRES_W'(MAX_RESULTS))
                     && (cnt_lessd >= CNT_W'(eff_bits));

    // sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_dir       = r_dir;
        n_code_bits = r_code_bits;
        n_modulus   = r_modulus;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_step      = r_step;
        n_nres      = r_nres;
        n_fin       = r_fin;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_mcode     = r_mcode;
        n_acc       = r_acc;
        n_res_last  = r_res_last;
        n_out_value = r_out_value;
        n_out_final = r_out_final;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_fin  = i_final_item;
                    n_nres = '0;
                    if (r_dir == DIR_COMPRESS) begin
                        n_neg  = smp_u[SAMPLE_W-1];
                        n_mag  = smp_u[SAMPLE_W-1] ? (~smp_u + SAMPLE_W'(1)) : smp_u;
                        n_rem  = '0;
                        n_quo  = '0;
                        n_step = STEP_W'(SAMPLE_W);
                        n_state = (r_modulus == '0) ? S_PACK : S_MOD;
                    end else begin
                        n_buf   = r_buf | (BUF_W'(smp_u[BYTE_W-1:0]) << r_cnt);
                        n_cnt   = r_cnt + CNT_W'(BYTE_W);
                        n_state = S_DCHK;
                    end
                end
            end
            // magnitude modulo q, one bit a cycle
            S_MOD: begin
                n_rem  = add_ok ? add_sum[MW-1:0] : mod_part[MW-1:0];
                n_mag  = r_mag << 1;
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = S_FIX;
                end
            end
            // negative input: take q minus the remainder
            S_FIX: begin
                if (r_neg && r_rem != '0) begin
                    n_rem = add_sum[MW-1:0];
                end
                n_step  = STEP_W'(eff_bits);
                n_state = S_DIV;
            end
            // quotient of r * 2^d by q, one bit a cycle
            S_DIV: begin
                n_rem  = add_ok ? add_sum[MW-1:0] : div_part[MW-1:0];
                n_quo  = {r_quo[MAX_CODE_BITS-2:0], add_ok};
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = S_RADD;
                end
            end
            // remainder plus half q
            S_RADD: begin
                n_acc   = add_sum[ADD_W-1:0];
                n_state = S_RCMP;
            end
            // round up when that reaches q
            S_RCMP: begin
                if (add_ok) begin
                    n_quo = r_quo + MAX_CODE_BITS'(1);
                end
                n_state = S_PACK;
            end
            // append the code to the bit buffer
            S_PACK: begin
                n_buf   = r_buf | (BUF_W'(r_quo & code_mask) << r_cnt);
                n_cnt   = r_cnt + CNT_W'(eff_bits);
                n_state = S_CEMIT;
            end
            // emit complete bytes, then the partial byte on a final item
            S_CEMIT: begin
                if (r_cnt >= CNT_W'(BYTE_W) && room) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_value = VALUE_W'(r_buf[BYTE_W-1:0]);
                        n_out_final = r_fin && !more_c;
                        n_buf       = r_buf >> BYTE_W;
                        n_cnt       = cnt_less8;
                        n_nres      = nres_inc;
                    end
                end else if (r_fin && r_cnt != '0 && room) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_value = VALUE_W'(r_buf[BYTE_W-1:0]);
                        n_out_final = 1'b1;
                        n_buf       = '0;
                        n_cnt       = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    if (r_fin) begin
                        n_buf = '0;
                        n_cnt = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            // take the next complete code from the buffer
            S_DCHK: begin
                if (r_cnt >= CNT_W'(eff_bits) && room) begin
                    n_mcode    = dcode << align_sh;
                    n_acc      = '0;
                    n_step     = STEP_W'(eff_bits);
                    n_buf      = r_buf >> eff_bits;
                    n_cnt      = cnt_lessd;
                    n_nres     = nres_inc;
                    n_res_last = r_fin && !more_d;
                    n_state    = S_MUL;
                end else begin
                    if (r_fin) begin
                        n_buf = '0;
                        n_cnt = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            // code times q, msb first shift-add
            S_MUL: begin
                n_acc   = add_sum[ADD_W-1:0];
                n_mcode = r_mcode << 1;
                n_step  = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = S_MRND;
                end
            end
            // add half an lsb of the code scale
            S_MRND: begin
                n_acc   = add_sum[ADD_W-1:0];
                n_state = S_MOUT;
            end
            // scale down and hand over the coefficient
            S_MOUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = VALUE_W'(r_acc >> eff_bits);
                    n_out_final = r_res_last;
                    n_state     = S_DCHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register writes, which also empty the bit buffer
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DIRECTION: begin
                    n_dir = i_cfg_data[0];
                    n_buf = '0;
                    n_cnt = '0;
                end
                CFG_CODE_BITS: begin
                    n_code_bits = i_cfg_data[CODE_BITS_W-1:0];
                    n_buf       = '0;
                    n_cnt       = '0;
                end
                CFG_MODULUS: begin
                    n_modulus = i_cfg_data;
                    n_buf     = '0;
                    n_cnt     = '0;
                end
                default: begin
                    n_dir = r_dir;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dir       <= DIR_COMPRESS;
            r_code_bits <= RST_CODE_BITS;
            r_modulus   <= MW'(RST_MODULUS);
            r_buf       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dir       <= n_dir;
            r_code_bits <= n_code_bits;
            r_modulus   <= n_modulus;
            r_buf       <= n_buf;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_nres      <= n_nres;
        r_fin       <= n_fin;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_mcode     <= n_mcode;
        r_acc       <= n_acc;
        r_res_last  <= n_res_last;
        r_out_value <= n_out_value;
        r_out_final <= n_out_final;
    end

    // ports
    assign o_stall        = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_value        = r_out_value;
    assign o_final_result = r_out_final;

endmodule

`default_nettype wire

// ===== sv/lcc_checker.sv =====
// port level checks for the coefficient codec, bound to the top level
`default_nettype none

module lcc_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_valid,
    input wire o_stall,
    input wire o_valid,
    input wire i_stall,
    input wire [lcc_pkg::VALUE_W-1:0] o_value,
    input wire o_final_result,
    input wire o_cfg_ready
);

    // a stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_final_result))
        else $error("output beat changed while stalled");

    // an accepted input beat keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again right after an accepted beat");

    // register writes are taken only while no item is in work
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready != o_stall)
        else $error("config ready and input stall disagree");

    // reset leaves no output beat and an idle input side
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not cleared by reset");

endmodule

bind lattice_coeff_compress_codec lcc_checker u_lcc_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking bench for the coefficient compress / decompress codec
`default_nettype none

module testbench;

    import lcc_pkg::*;

    localparam int MAX_BITS      = DEF_MAX_CODE_BITS;
    localparam int BUF_MASK      = 32'h3FFFF;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int STUCK_LIMIT   = 4000;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_ITEM,
        ST_REG,
        ST_DRAIN,
        ST_MODE,
        ST_HOLD
    } t_step_kind;

    typedef struct packed {
        t_step_kind               kind;
        logic [SAMPLE_W-1:0]      sample;
        logic                     last;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [DEF_MODULUS_WIDTH-1:0] reg_data;
        logic [6:0]               send_pct;
        logic [6:0]               stall_pct;
    } t_codec_step;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_codec_word;

    // block ports
    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_valid = 1'b0;
    logic                                 o_stall;
    logic signed [SAMPLE_W-1:0]           i_sample = '0;
    logic                                 i_final_item = 1'b0;
    logic                                 o_valid;
    logic                                 i_stall = 1'b0;
    logic        [VALUE_W-1:0]            o_value;
    logic                                 o_final_result;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic        [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic        [DEF_MODULUS_WIDTH-1:0]  i_cfg_data = '0;

    // stimulus plan and values the block still owes
    t_codec_step plan [$];
    t_codec_word owed_values [$];

    // mirror of the block's registers and bit buffer
    logic                   dir_q = DIR_COMPRESS;
    logic [CODE_BITS_W-1:0] width_q = RST_CODE_BITS;
    int                     mod_q = RST_MODULUS;
    int                     held_bits = 0;
    int                     held_count = 0;

    // driver, receiver and watchdog state
    int          errors = 0;
    int          quiet_cycles = 0;
    int          send_pct = 0;
    int          stall_pct = 0;
    int          hold_asks = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stuck_cycles = 0;
    logic        sent_now;
    logic        offer;
    logic        cfg_offer;
    t_codec_step step;
    t_codec_word want;

    int width_pick [10] = '{0, 1, 2, 3, 4, 5, 7, 11, 12, 15};
    int mod_pick [7]    = '{0, 1, 2, 3, 3329, 7681, 8191};

    lattice_coeff_compress_codec u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_final_item   (i_final_item),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_value        (o_value),
        .o_final_result (o_final_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register write as seen by the block; any index in range empties the buffer
    function automatic void set_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [DEF_MODULUS_WIDTH-1:0] data);
        logic hit;
        hit = 1'b1;
        case (idx)
            CFG_DIRECTION: dir_q = data[0];
            CFG_CODE_BITS: width_q = data[CODE_BITS_W-1:0];
            CFG_MODULUS:   mod_q = int'(data);
            default:       hit = 1'b0;
        endcase
        if (hit) begin
            held_bits = 0;
            held_count = 0;
        end
    endfunction

    // one input beat: pack rounded codes into bytes, or unpack bytes into coefficients
    function automatic void code_sample(logic [SAMPLE_W-1:0] smp, logic fin);
        int          d;
        int          q;
        int          r;
        int          code;
        int          n;
        int          i;
        longint      num;
        int          outs [3];
        t_codec_word w;
        n = 0;
        q = mod_q;
        d = int'(width_q);
        if (d == 0) d = 1;
        if (d > MAX_BITS) d = MAX_BITS;
        if (dir_q == DIR_COMPRESS) begin
            if (q == 0) begin
                code = 0;
            end else begin
                r = int'($signed(smp));
                r = r % q;
                if (r < 0) r += q;
                num = (longint'(r) << d) + longint'(q / 2);
                code = int'(num / longint'(q)) & ((1 << d) - 1);
            end
            held_bits = (held_bits | (code << held_count)) & BUF_MASK;
            held_count += d;
            while (held_count >= 8 && n < 3) begin
                outs[n] = held_bits & 8'hFF;
                n++;
                held_bits = held_bits >> 8;
                held_count -= 8;
            end
            // final coefficient flushes a partial byte
            if (fin && held_count > 0 && n < 3) begin
                outs[n] = held_bits & 8'hFF;
                n++;
            end
        end else begin
            if (d < MIN_DECOMP_BITS) d = MIN_DECOMP_BITS;
            held_bits = (held_bits | (int'(smp[BYTE_W-1:0]) << held_count)) & BUF_MASK;
            held_count += 8;
            while (held_count >= d && n < 3) begin
                code = held_bits & ((1 << d) - 1);
                outs[n] = ((code * q + (1 << (d - 1))) >> d) & 13'h1FFF;
                n++;
                held_bits = held_bits >> d;
                held_count -= d;
            end
        end
        for (i = 0; i < n; i++) begin
            w.value = outs[i][VALUE_W-1:0];
            w.last = fin && (i == n - 1);
            owed_values.push_back(w);
        end
        if (fin) begin
            held_bits = 0;
            held_count = 0;
        end
    endfunction

    // plan builders
    function automatic void add_item(int smp, logic fin);
        t_codec_step s;
        s = '0;
        s.kind = ST_ITEM;
        s.sample = smp[SAMPLE_W-1:0];
        s.last = fin;
        plan.push_back(s);
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int data);
        t_codec_step s;
        s = '0;
        s.kind = ST_REG;
        s.reg_idx = idx;
        s.reg_data = data[DEF_MODULUS_WIDTH-1:0];
        plan.push_back(s);
    endfunction

    function automatic void add_mode(int send, int stall);
        t_codec_step s;
        s = '0;
        s.kind = ST_MODE;
        s.send_pct = send[6:0];
        s.stall_pct = stall[6:0];
        plan.push_back(s);
    endfunction

    function automatic void add_marker(t_step_kind kind);
        t_codec_step s;
        s = '0;
        s.kind = kind;
        plan.push_back(s);
    endfunction

    function automatic int any_coeff();
        return int'($urandom_range(16382)) - 8191;
    endfunction

    // driver: input beats, register writes, idling modes and hold requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            sent_now = i_valid && !o_stall;
            if (sent_now) code_sample(i_sample, i_final_item);
            if (i_cfg_valid && o_cfg_ready) set_register(i_cfg_index, i_cfg_data);
            // a beat may give no result while the block is still busy with it
            if (sent_now || owed_values.size() != 0) quiet_cycles = 0;
            else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
            offer = i_valid && o_stall;
            cfg_offer = i_cfg_valid && !o_cfg_ready;
            if (!offer && !cfg_offer && plan.size() != 0) begin
                step = plan[0];
                case (step.kind)
                    ST_ITEM: begin
                        if ($urandom_range(99) >= send_pct) begin
                            offer = 1'b1;
                            i_sample <= step.sample;
                            i_final_item <= step.last;
                            void'(plan.pop_front());
                        end
                    end
                    ST_REG: begin
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            cfg_offer = 1'b1;
                            i_cfg_index <= step.reg_idx;
                            i_cfg_data <= step.reg_data;
                            void'(plan.pop_front());
                        end
                    end
                    ST_DRAIN: begin
                        if (owed_values.size() == 0) void'(plan.pop_front());
                    end
                    ST_MODE: begin
                        send_pct = int'(step.send_pct);
                        stall_pct <= int'(step.stall_pct);
                        void'(plan.pop_front());
                    end
                    ST_HOLD: begin
                        hold_asks <= hold_asks + 1;
                        void'(plan.pop_front());
                    end
                    default: void'(plan.pop_front());
                endcase
            end
            i_valid <= offer;
            i_cfg_valid <= cfg_offer;
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            i_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
        end
    end

    // monitor: every output beat against the oldest owed value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_values.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat value %0d final %0b",
                         $time, o_value, o_final_result);
            end else begin
                want = owed_values.pop_front();
                if (o_value !== want.value) begin
                    errors++;
                    $display("%0t: value expected %0d actual %0d",
                             $time, want.value, o_value);
                end
                if (o_final_result !== want.last) begin
                    errors++;
                    $display("%0t: final flag expected %0b actual %0b",
                             $time, want.last, o_final_result);
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    // stimulus plan, reset and end of run
    initial begin
        int p;
        int k;
        int len;
        int fill;
        int nb;
        int nq;
        int smp;
        logic is_decomp;
        logic broken;

        // reset setting: compress, ten-bit codes, q = 7681
        add_item(-8191, 1'b0);
        add_item(-7682, 1'b0);
        add_item(-7681, 1'b0);
        add_item(-1, 1'b0);
        add_item(0, 1'b0);
        add_item(1, 1'b0);
        add_item(3840, 1'b0);
        add_item(7680, 1'b0);
        add_item(8191, 1'b1);
        // zero width acts as one bit, zero modulus gives zero codes
        add_reg(CFG_CODE_BITS, 0);
        add_reg(CFG_MODULUS, 0);
        add_item(1234, 1'b0);
        add_item(-5, 1'b0);
        add_item(77, 1'b1);
        // oversize width saturates; a write to the unused index keeps the buffer
        add_reg(CFG_CODE_BITS, 15);
        add_reg(CFG_MODULUS, 3329);
        add_item(-8191, 1'b0);
        add_item(3328, 1'b0);
        add_reg(CFG_UNUSED, 13'h1FFF);
        add_item(-3329, 1'b0);
        add_item(1665, 1'b1);
        // unpacking with a narrow width acts as three bits
        add_reg(CFG_DIRECTION, 13'h1FFF);
        add_reg(CFG_CODE_BITS, 1);
        add_item(255, 1'b0);
        add_item(0, 1'b0);
        add_item(90, 1'b1);
        // widest codes; a final byte with no whole code gives no beat
        add_reg(CFG_CODE_BITS, 11);
        add_reg(CFG_MODULUS, 8191);
        add_item(255, 1'b0);
        add_item(128, 1'b1);
        add_item(18, 1'b1);
        // zero modulus when unpacking
        add_reg(CFG_CODE_BITS, 4);
        add_reg(CFG_MODULUS, 0);
        add_item(171, 1'b1);

        // random phases over settings and idling modes
        for (p = 0; p < PHASES; p++) begin
            is_decomp = p[0];
            nb = (p < 10) ? width_pick[p] : int'($urandom_range(15));
            nq = (p < 7) ? mod_pick[p] : int'($urandom_range(8191, 3));
            add_reg(CFG_DIRECTION, int'($urandom & 32'h1FFE) | int'(is_decomp));
            add_reg(CFG_CODE_BITS, int'($urandom & 32'h1FF0) | nb);
            add_reg(CFG_MODULUS, nq);
            if (p == 6) begin
                // long receiver hold-off while beats keep coming
                add_mode(0, 0);
                add_marker(ST_HOLD);
            end else begin
                case (p % 4)
                    0: add_mode(0, 0);
                    1: add_mode(78, 0);
                    2: add_mode(0, 78);
                    default: add_mode(21, 21);
                endcase
            end
            fill = 0;
            while (fill < PHASE_ITEMS) begin
                len = $urandom_range(12, 1);
                broken = ($urandom_range(9) == 0);
                for (k = 0; k < len; k++) begin
                    if (is_decomp) begin
                        smp = ($urandom_range(5) == 0) ? any_coeff()
                                                       : int'($urandom_range(255));
                    end else if ($urandom_range(7) == 0) begin
                        case ($urandom_range(5))
                            0: smp = -8191;
                            1: smp = 8191;
                            2: smp = -nq;
                            3: smp = nq - 1;
                            4: smp = 0;
                            default: smp = -1;
                        endcase
                    end else begin
                        smp = any_coeff();
                    end
                    add_item(smp, (k == len - 1) && !broken);
                    fill++;
                end
                if ($urandom_range(7) == 0) add_marker(ST_DRAIN);
                if ($urandom_range(19) == 0) add_reg(CFG_UNUSED, int'($urandom));
            end
            // sender waits for every owed beat
            if (p == 6) add_marker(ST_DRAIN);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (plan.size() != 0 || i_valid || i_cfg_valid || owed_values.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0 && owed_values.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
